>>> hw/rtl/mwrs_pkg.sv
// ----------------------------------------------------------------------------
// mwrs_pkg
// Shared port codes, configuration register indexes and lane numbering for
// the weighted minimal route selector.
// ----------------------------------------------------------------------------
package mwrs_pkg;

  localparam int PORT_W = 3;

  typedef enum logic [PORT_W-1:0] {
    PORT_LOCAL = 3'd0,
    PORT_NORTH = 3'd1,
    PORT_SOUTH = 3'd2,
    PORT_EAST  = 3'd3,
    PORT_WEST  = 3'd4
  } port_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_DIM_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_ID   = 2'd0,
    CFG_MESH_ROWS = 2'd1,
    CFG_MESH_COLS = 2'd2
  } cfg_index_t;

  localparam logic [CFG_DATA_W-1:0] NODE_ID_RESET   = 8'd0;
  localparam logic [CFG_DIM_W-1:0]  MESH_ROWS_RESET = 5'd16;
  localparam logic [CFG_DIM_W-1:0]  MESH_COLS_RESET = 5'd16;

  // Three tile ids are divided side by side in every cell.
  localparam int NUM_LANES = 3;
  localparam int LANE_SRC  = 0;
  localparam int LANE_DST  = 1;
  localparam int LANE_ME   = 2;

endpackage

>>> hw/rtl/mwrs_in_if.sv
// ----------------------------------------------------------------------------
// mwrs_in_if
// Header channel into the route selector: valid/ready plus packet header.
// ----------------------------------------------------------------------------
interface mwrs_in_if import mwrs_pkg::*; #(
  parameter int ID_BITS = 8
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] source_tile;
  logic [ID_BITS-1:0] dest_tile;
  logic [PORT_W-1:0]  arrival_port;

  modport source (output valid, source_tile, dest_tile, arrival_port, input ready);
  modport sink   (input valid, source_tile, dest_tile, arrival_port, output ready);
endinterface

>>> hw/rtl/mwrs_out_if.sv
// ----------------------------------------------------------------------------
// mwrs_out_if
// Result channel out of the route selector: valid/ready plus chosen port.
// ----------------------------------------------------------------------------
interface mwrs_out_if import mwrs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, out_port, input ready);
  modport sink   (input valid, out_port, output ready);
endinterface

>>> hw/rtl/mesh_weighted_minimal_route_select.sv
// ----------------------------------------------------------------------------
// mesh_weighted_minimal_route_select
// Output port choice for one 2D mesh router with a weighted minimal choice
// between the row axis and the column axis.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake      | Payload
//   --------+-----------+----------------+----------------------------------
//   in_ch   | sink      | valid / ready  | source_tile, dest_tile, arrival_port
//   out_ch  | source    | valid / ready  | out_port
//   cfg_*   | sink      | cfg_we only    | cfg_index, cfg_wdata
//
// One header beat is accepted per cycle and one result beat leaves per cycle
// while the output is not stalled. A chain of ID_BITS division cells, one
// quotient bit per cell, splits the three tile ids into row and column, and
// three stages follow for distances, products and the biased compare.
// Every stage has its own valid bit and a ready that passes back through it,
// so empty stages fill even while the output beat is held by a stall.
// Reset clears all valid bits and sets the mesh to 16 by 16 with node 0.
// Configuration writes are expected only while no beat is in flight.
//
module mesh_weighted_minimal_route_select import mwrs_pkg::*; #(
  parameter int MAX_DIM = 16,
  parameter int ID_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  mwrs_in_if.sink               in_ch,
  mwrs_out_if.source            out_ch
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int SCALE_W = 2 * DIM_W;

  // Configuration registers, kept at their programmed widths.
  logic [CFG_DATA_W-1:0] node_id_r;
  logic [CFG_DIM_W-1:0]  mesh_rows_r;
  logic [CFG_DIM_W-1:0]  mesh_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r   <= NODE_ID_RESET;
      mesh_rows_r <= MESH_ROWS_RESET;
      mesh_cols_r <= MESH_COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:   node_id_r   <= cfg_wdata;
        CFG_MESH_ROWS: mesh_rows_r <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_MESH_COLS: mesh_cols_r <= cfg_wdata[CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero dimension is taken as one and anything above MAX_DIM as MAX_DIM.
  logic [DIM_W-1:0] rows_cl, cols_cl;

  always_comb begin
    if (mesh_rows_r == '0) begin
      rows_cl = DIM_W'(1);
    end else if (int'(mesh_rows_r) > MAX_DIM) begin
      rows_cl = DIM_W'(MAX_DIM);
    end else begin
      rows_cl = DIM_W'(mesh_rows_r);
    end
    if (mesh_cols_r == '0) begin
      cols_cl = DIM_W'(1);
    end else if (int'(mesh_cols_r) > MAX_DIM) begin
      cols_cl = DIM_W'(MAX_DIM);
    end else begin
      cols_cl = DIM_W'(mesh_cols_r);
    end
  end

  // The mesh size product scales both sides of the compare. It only changes
  // with configuration, and a beat needs it long after it enters.
  logic [SCALE_W-1:0] scale_r;

  always_ff @(posedge clk) begin
    scale_r <= SCALE_W'(rows_cl) * SCALE_W'(cols_cl);
  end

  // Links between the division cells; link 0 is the input side.
  logic [ID_BITS:0]                  lk_valid;
  logic [ID_BITS:0]                  lk_ready;
  logic [NUM_LANES-1:0][ID_BITS-1:0] lk_word [ID_BITS+1];
  logic [NUM_LANES-1:0][DIM_W-1:0]   lk_rem  [ID_BITS+1];
  logic [PORT_W-1:0]                 lk_port [ID_BITS+1];

  assign lk_valid[0]          = in_ch.valid;
  assign in_ch.ready          = lk_ready[0];
  assign lk_word[0][LANE_SRC] = in_ch.source_tile;
  assign lk_word[0][LANE_DST] = in_ch.dest_tile;
  assign lk_word[0][LANE_ME]  = ID_BITS'(node_id_r);
  assign lk_rem[0]            = '0;
  assign lk_port[0]           = in_ch.arrival_port;

  for (genvar i = 0; i < ID_BITS; i++) begin : g_cell
    mwrs_cell #(
      .ID_BITS (ID_BITS),
      .DIM_W   (DIM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (cols_cl),
      .up_valid (lk_valid[i]),
      .up_ready (lk_ready[i]),
      .up_word  (lk_word[i]),
      .up_rem   (lk_rem[i]),
      .up_port  (lk_port[i]),
      .dn_valid (lk_valid[i+1]),
      .dn_ready (lk_ready[i+1]),
      .dn_word  (lk_word[i+1]),
      .dn_rem   (lk_rem[i+1]),
      .dn_port  (lk_port[i+1])
    );
  end

  // After the last cell each word holds a row number and each remainder
  // a column number.
  mwrs_decide #(
    .ID_BITS (ID_BITS),
    .DIM_W   (DIM_W)
  ) u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .scale    (scale_r),
    .up_valid (lk_valid[ID_BITS]),
    .up_ready (lk_ready[ID_BITS]),
    .up_quo   (lk_word[ID_BITS]),
    .up_rem   (lk_rem[ID_BITS]),
    .up_port  (lk_port[ID_BITS]),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_port  (out_ch.out_port)
  );

`ifndef ASSERT_OFF
  // Input back-pressure only arises when every stage is full, which in turn
  // means the output beat is being held.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input blocked while the output is not stalled");

  // A result beat always carries one of the five real ports.
  a_port_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.out_port == PORT_LOCAL) ||
                      (out_ch.out_port == PORT_NORTH) ||
                      (out_ch.out_port == PORT_SOUTH) ||
                      (out_ch.out_port == PORT_EAST)  ||
                      (out_ch.out_port == PORT_WEST)))
    else $error("result beat with an undefined port code");
`endif

endmodule

>>> hw/rtl/mwrs_cell.sv
// ----------------------------------------------------------------------------
// mwrs_cell
// One restoring division step for three tile ids at once. The dividend word
// shifts left; the freed low bit takes the new quotient bit, so after a full
// chain of cells the word holds the quotient and rem holds the remainder.
// ----------------------------------------------------------------------------
module mwrs_cell import mwrs_pkg::*; #(
  parameter int ID_BITS = 8,
  parameter int DIM_W   = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [DIM_W-1:0]                   divisor,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic [NUM_LANES-1:0][ID_BITS-1:0]  up_word,
  input  logic [NUM_LANES-1:0][DIM_W-1:0]    up_rem,
  input  logic [PORT_W-1:0]                  up_port,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic [NUM_LANES-1:0][ID_BITS-1:0]  dn_word,
  output logic [NUM_LANES-1:0][DIM_W-1:0]    dn_rem,
  output logic [PORT_W-1:0]                  dn_port
);

  logic                              valid_r;
  logic [NUM_LANES-1:0][ID_BITS-1:0] word_r, word_nxt;
  logic [NUM_LANES-1:0][DIM_W-1:0]   rem_r, rem_nxt;
  logic [PORT_W-1:0]                 port_r;

  always_comb begin
    logic [DIM_W:0] rem_sh;
    logic           ge;
    word_nxt = '0;
    rem_nxt  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_sh      = {up_rem[l], up_word[l][ID_BITS-1]};
      ge          = (rem_sh >= {1'b0, divisor});
      rem_nxt[l]  = ge ? DIM_W'(rem_sh - {1'b0, divisor}) : DIM_W'(rem_sh);
      word_nxt[l] = {up_word[l][ID_BITS-2:0], ge};
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
      rem_r  <= rem_nxt;
      port_r <= up_port;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;
  assign dn_rem   = rem_r;
  assign dn_port  = port_r;

endmodule

>>> hw/rtl/mwrs_decide.sv
// ----------------------------------------------------------------------------
// mwrs_decide
// Three-stage back end: distances and flags, scaled products, then the
// biased compare that picks the output port.
// ----------------------------------------------------------------------------
module mwrs_decide import mwrs_pkg::*; #(
  parameter int ID_BITS = 8,
  parameter int DIM_W   = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [2*DIM_W-1:0]                 scale,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic [NUM_LANES-1:0][ID_BITS-1:0]  up_quo,
  input  logic [NUM_LANES-1:0][DIM_W-1:0]    up_rem,
  input  logic [PORT_W-1:0]                  up_port,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic [PORT_W-1:0]                  dn_port
);

  localparam int PROW_W = ID_BITS + 2 * DIM_W;
  localparam int PCOL_W = 3 * DIM_W;
  localparam int MN_W   = ID_BITS + DIM_W + 2;
  localparam int BIAS_W = MN_W + 2;
  localparam int SUM_W  = ID_BITS + 3 * DIM_W + 4;

  typedef struct packed {
    logic at_dest;
    logic go_south;
    logic go_east;
    logic row_bias;
    logic col_bias;
  } route_flags_t;

  // Stage A: distances.
  logic               a_valid_r;
  logic [ID_BITS-1:0] a_x_r, a_m_r, a_x_nxt, a_m_nxt;
  logic [DIM_W-1:0]   a_y_r, a_n_r, a_y_nxt, a_n_nxt;
  route_flags_t       a_flags_r, a_flags_nxt;
  logic               a_ready;

  // Stage B: products.
  logic               b_valid_r;
  logic [PROW_W-1:0]  b_prow_r;
  logic [PCOL_W-1:0]  b_pcol_r;
  logic [BIAS_W-1:0]  b_bias_r;
  route_flags_t       b_flags_r;
  logic               b_ready;

  // Stage C: decision, doubles as the output register.
  logic               c_valid_r;
  logic [PORT_W-1:0]  c_port_r, c_port_nxt;
  logic               c_ready;

  assign c_ready  = !c_valid_r || dn_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  always_comb begin
    logic [ID_BITS-1:0] me_r, d_r, s_r;
    logic [DIM_W-1:0]   me_c, d_c, s_c;
    logic               not_src;
    me_r = up_quo[LANE_ME];
    d_r  = up_quo[LANE_DST];
    s_r  = up_quo[LANE_SRC];
    me_c = up_rem[LANE_ME];
    d_c  = up_rem[LANE_DST];
    s_c  = up_rem[LANE_SRC];
    a_x_nxt = (d_r >= me_r) ? d_r - me_r : me_r - d_r;
    a_y_nxt = (d_c >= me_c) ? d_c - me_c : me_c - d_c;
    a_m_nxt = (d_r >= s_r) ? d_r - s_r : s_r - d_r;
    a_n_nxt = (d_c >= s_c) ? d_c - s_c : s_c - d_c;
    // Equal quotient and remainder under one divisor means equal tile ids.
    not_src = (me_r != s_r) || (me_c != s_c);
    a_flags_nxt.at_dest  = (a_x_nxt == '0) && (a_y_nxt == '0);
    a_flags_nxt.go_south = (me_r < d_r);
    a_flags_nxt.go_east  = (me_c < d_c);
    a_flags_nxt.row_bias = not_src && (a_x_nxt != '0) &&
                           ((up_port == PORT_NORTH) || (up_port == PORT_SOUTH));
    a_flags_nxt.col_bias = not_src && (a_y_nxt != '0) &&
                           ((up_port == PORT_EAST) || (up_port == PORT_WEST));
  end

  always_comb begin
    logic [SUM_W-1:0] p_row, p_col;
    p_row = SUM_W'(b_prow_r) + (b_flags_r.row_bias ? SUM_W'(b_bias_r) : '0);
    p_col = SUM_W'(b_pcol_r) + (b_flags_r.col_bias ? SUM_W'(b_bias_r) : '0);
    if (b_flags_r.at_dest) begin
      c_port_nxt = PORT_LOCAL;
    end else if (p_row >= p_col) begin
      c_port_nxt = b_flags_r.go_south ? PORT_SOUTH : PORT_NORTH;
    end else begin
      c_port_nxt = b_flags_r.go_east ? PORT_EAST : PORT_WEST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_ready) begin
      a_x_r     <= a_x_nxt;
      a_y_r     <= a_y_nxt;
      a_m_r     <= a_m_nxt;
      a_n_r     <= a_n_nxt;
      a_flags_r <= a_flags_nxt;
    end
    if (a_valid_r && b_ready) begin
      b_prow_r  <= PROW_W'(a_x_r) * PROW_W'(scale);
      b_pcol_r  <= PCOL_W'(a_y_r) * PCOL_W'(scale);
      b_bias_r  <= BIAS_W'((MN_W'(a_m_r) + MN_W'(1)) * (MN_W'(a_n_r) + MN_W'(1))) << 2;
      b_flags_r <= a_flags_r;
    end
    if (b_valid_r && c_ready) begin
      c_port_r <= c_port_nxt;
    end
  end

  assign dn_valid = c_valid_r;
  assign dn_port  = c_port_r;

endmodule
